// ===== rtl/cwc_pkg.sv =====
// shared types, constants and check functions for the compound wait compare block
`default_nettype none

package cwc_pkg;

    localparam int unsigned EVT_W   = 4;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned HEAD_W  = 32;
    localparam int unsigned POS_W   = 3;
    localparam int unsigned HALF_W  = 16;

    // bytes kept at the head of each stream
    localparam logic [POS_W-1:0] HEAD_BYTES = 3'd4;

    typedef enum logic [2:0] {
        MODE_EXACT    = 3'd0,
        MODE_ALL_SET  = 3'd1,
        MODE_NONE_SET = 3'd2,
        MODE_RSVD     = 3'd3,
        MODE_HI_GE    = 3'd4,
        MODE_HI_LE    = 3'd5,
        MODE_LO_GE    = 3'd6,
        MODE_LO_LE    = 3'd7
    } cwc_mode_t;

    // per-byte check of one payload/status pair
    function automatic logic byte_ok(input cwc_mode_t mode,
                                     input logic [BYTE_W-1:0] p,
                                     input logic [BYTE_W-1:0] s);
        logic ok;
        ok = 1'b1;
        unique case (mode)
            MODE_EXACT:    ok = (p == s);
            MODE_ALL_SET:  ok = ((p & s) == p);
            MODE_NONE_SET: ok = ((p & s) == '0);
            default:       ok = 1'b1;
        endcase
        return ok;
    endfunction

    // end-of-comparison verdict from the accumulated state
    function automatic logic final_match(input logic ok,
                                         input cwc_mode_t mode,
                                         input logic full,
                                         input logic [HEAD_W-1:0] ph,
                                         input logic [HEAD_W-1:0] sh);
        logic m;
        m = 1'b0;
        unique case (mode)
            MODE_EXACT, MODE_ALL_SET, MODE_NONE_SET: m = 1'b1;
            MODE_HI_GE: m = full && (ph[HEAD_W-1:HALF_W] >= sh[HEAD_W-1:HALF_W]);
            MODE_HI_LE: m = full && (ph[HEAD_W-1:HALF_W] <= sh[HEAD_W-1:HALF_W]);
            MODE_LO_GE: m = full && (ph[HALF_W-1:0] >= sh[HALF_W-1:0]);
            MODE_LO_LE: m = full && (ph[HALF_W-1:0] <= sh[HALF_W-1:0]);
            MODE_RSVD:  m = 1'b0;
            default:    m = 1'b0;
        endcase
        return ok && m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/compound_wait_compare_core.sv =====
// compound wait compare: checks a payload pattern against a status read-back
//
// usage
// - slave channel carries one payload/status byte pair per transaction;
//   s_tlast marks the final pair of a comparison, s_tuser carries the event
//   code (its low three bits pick the mode on the first transaction of a
//   comparison), the status-present flag and the empty-payload flag
// - master channel carries one match bit per comparison, given on the
//   transaction that closed it (s_tlast, or an empty payload on the first one)
// - result path: two registers, the input register and then the result
//   register, lie between a closing transaction and its result on m_tvalid
// - throughput: one transaction per cycle unless the stall below holds the
//   input register; the slave side keeps taking transactions while a result
//   waits in the result register, as long as they do not close a comparison
// - when the receiver stalls with a result pending and the next closing
//   transaction sits in the input register, s_tready drops until m_tready
// - reset (aresetn low, synchronous) empties both registers and starts a
//   fresh comparison; no clearing pass is needed
`default_nettype none

module compound_wait_compare_core
    import cwc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // slave side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // [7:0] payload_byte, [15:8] status_byte
    input  wire logic [5:0]  s_tuser,  // [3:0] event_code, [4] status_present, [5] empty_payload
    input  wire logic        s_tlast,  // last_item
    // master side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata   // [0] match, [7:1] zero
);

    // input register
    logic                  in_vld_reg;
    logic [EVT_W-1:0]      in_evt_reg;
    logic [BYTE_W-1:0]     in_pay_reg;
    logic [BYTE_W-1:0]     in_sts_reg;
    logic                  in_present_reg;
    logic                  in_empty_reg;
    logic                  in_last_reg;

    // comparison state
    cwc_mode_t             mode_held_reg, mode_held_next;
    logic                  running_ok_reg, running_ok_next;
    logic [POS_W-1:0]      byte_pos_reg, byte_pos_next;
    logic [HEAD_W-1:0]     pay_head_reg, pay_head_next;
    logic [HEAD_W-1:0]     sts_head_reg, sts_head_next;
    logic                  in_progress_reg, in_progress_next;

    // result register
    logic                  out_vld_reg;
    logic                  match_reg;

    logic                  first;
    logic                  early_empty;
    logic                  emits;
    logic                  result;
    logic                  st_fire;
    cwc_mode_t             mode_cur;
    logic                  ok_base;
    logic [POS_W-1:0]      pos_base;
    logic [HEAD_W-1:0]     pay_base, sts_base;

    // datapath: state update for the transaction in the input register
    always_comb begin
        first       = !in_progress_reg;
        mode_cur    = first ? cwc_mode_t'(in_evt_reg[2:0]) : mode_held_reg;
        ok_base     = first ? 1'b1 : running_ok_reg;
        pos_base    = first ? '0 : byte_pos_reg;
        pay_base    = first ? '0 : pay_head_reg;
        sts_base    = first ? '0 : sts_head_reg;
        early_empty = first && in_empty_reg;

        mode_held_next   = mode_cur;
        running_ok_next  = ok_base && in_present_reg && byte_ok(mode_cur, in_pay_reg, in_sts_reg);
        byte_pos_next    = pos_base;
        pay_head_next    = pay_base;
        sts_head_next    = sts_base;
        if (pos_base < HEAD_BYTES) begin
            pay_head_next = {pay_base[HEAD_W-BYTE_W-1:0], in_pay_reg};
            sts_head_next = {sts_base[HEAD_W-BYTE_W-1:0], in_sts_reg};
            byte_pos_next = pos_base + 3'd1;
        end

        // empty payload on the first transaction passes only the bitwise modes
        if (early_empty) begin
            running_ok_next = 1'b1;
            byte_pos_next   = '0;
            pay_head_next   = '0;
            sts_head_next   = '0;
            result          = (mode_cur == MODE_EXACT) || (mode_cur == MODE_ALL_SET)
                           || (mode_cur == MODE_NONE_SET);
        end else begin
            result = final_match(running_ok_next, mode_cur,
                                 byte_pos_next >= HEAD_BYTES,
                                 pay_head_next, sts_head_next);
        end

        emits            = early_empty || in_last_reg;
        in_progress_next = !emits;
    end

    // input register moves on unless its result has nowhere to go
    assign st_fire  = in_vld_reg && (!emits || !out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || st_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            in_progress_reg <= 1'b0;
            mode_held_reg   <= MODE_EXACT;
            running_ok_reg  <= 1'b1;
            byte_pos_reg    <= '0;
            pay_head_reg    <= '0;
            sts_head_reg    <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (st_fire) begin
                in_vld_reg <= 1'b0;
            end

            if (st_fire) begin
                in_progress_reg <= in_progress_next;
                mode_held_reg   <= mode_held_next;
                running_ok_reg  <= running_ok_next;
                byte_pos_reg    <= byte_pos_next;
                pay_head_reg    <= pay_head_next;
                sts_head_reg    <= sts_head_next;
            end

            if (st_fire && emits) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_evt_reg     <= s_tuser[3:0];
            in_present_reg <= s_tuser[4];
            in_empty_reg   <= s_tuser[5];
            in_pay_reg     <= s_tdata[7:0];
            in_sts_reg     <= s_tdata[15:8];
            in_last_reg    <= s_tlast;
        end
        if (st_fire && emits) begin
            match_reg <= result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, match_reg};

    // checks
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_pos_reg <= HEAD_BYTES)
        else $error("byte position beyond head size");

    a_close_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        st_fire && emits |=> !in_progress_reg && m_tvalid)
        else $error("closing transaction did not end comparison");

    a_rsvd_fails: assert property (@(posedge aclk) disable iff (!aresetn)
        st_fire && emits && (mode_cur == MODE_RSVD) |-> !result)
        else $error("reserved mode produced a match");

    a_fail_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        st_fire && in_last_reg && !early_empty && !running_ok_next |-> !result)
        else $error("failed byte did not fail the comparison");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_vld_reg && emits && out_vld_reg && !m_tready)
        else $error("slave side stalled without a pending result");

endmodule

`default_nettype wire

// ===== tb/sv/compound_wait_compare_core_tb.sv =====
// testbench for compound_wait_compare_core: directed and random byte-pair streams
module compound_wait_compare_core_tb
    import cwc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // generous bound, far above the slowest legal run at the heaviest idling
    localparam int CYCLE_LIMIT  = 400000;
    // cycles to wait once every match has come back
    localparam int DRAIN_CYCLES = 16;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;  // [7:0] payload_byte, [15:8] status_byte
    logic [5:0]  s_tuser  = '0;  // [3:0] event_code, [4] status_present, [5] empty_payload
    logic        s_tlast  = 1'b0;  // last_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;  // [0] match, [7:1] zero

    compound_wait_compare_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // idling knobs, in percent per cycle, changed between phases
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    int items_sent  = 0;
    int error_count = 0;
    int cycle_count = 0;

    // expected match bits, oldest first
    logic match_q[$];

    // mirror of the comparison in flight
    cwc_mode_t        cmp_mode   = MODE_EXACT;
    logic             cmp_ok     = 1'b1;
    logic [POS_W-1:0] head_count = '0;
    logic [HEAD_W-1:0] pay_head  = '0;
    logic [HEAD_W-1:0] sta_head  = '0;
    logic             cmp_active = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // timeout watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("compound_wait_compare_core verification failed");
            $finish;
        end
    end

    // receiver backpressure, redrawn every cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker: every accepted match transaction against the oldest expectation
    always @(posedge aclk) begin
        logic [7:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (match_q.size() == 0) begin
                $display("%0t: unexpected match transaction, expected none actual %h",
                         $time, m_tdata);
                error_count++;
            end else begin
                want = {7'd0, match_q.pop_front()};
                if (m_tdata !== want) begin
                    $display("%0t: match mismatch, expected %h actual %h",
                             $time, want, m_tdata);
                    error_count++;
                end
            end
        end
    end

    // predicts the match bit, if any, caused by one accepted byte pair
    task automatic predict_pair(input logic [3:0] evt, input logic [7:0] pay,
                                input logic [7:0] sta, input logic present,
                                input logic empty, input logic last);
        logic verdict;
        logic full;
        // first transaction of a comparison samples the mode and clears the heads
        if (!cmp_active) begin
            cmp_mode   = cwc_mode_t'(evt[2:0]);
            cmp_ok     = 1'b1;
            head_count = '0;
            pay_head   = '0;
            sta_head   = '0;
            cmp_active = 1'b1;
            // empty payload closes at once; bytes and tlast do not matter
            if (empty) begin
                match_q.push_back(cmp_mode inside {MODE_EXACT, MODE_ALL_SET, MODE_NONE_SET});
                cmp_active = 1'b0;
                return;
            end
        end
        // a byte without a status byte sinks every mode
        if (!present) cmp_ok = 1'b0;
        case (cmp_mode)
            MODE_EXACT:    if (pay != sta) cmp_ok = 1'b0;
            MODE_ALL_SET:  if ((pay & sta) != pay) cmp_ok = 1'b0;
            MODE_NONE_SET: if ((pay & sta) != 8'h00) cmp_ok = 1'b0;
            default:       ;
        endcase
        // keep only the first four bytes, big-endian
        if (head_count < HEAD_BYTES) begin
            pay_head   = {pay_head[HEAD_W-BYTE_W-1:0], pay};
            sta_head   = {sta_head[HEAD_W-BYTE_W-1:0], sta};
            head_count = head_count + 1'b1;
        end
        if (last) begin
            full = (head_count >= HEAD_BYTES);
            case (cmp_mode)
                MODE_EXACT, MODE_ALL_SET, MODE_NONE_SET: verdict = 1'b1;
                MODE_HI_GE: verdict = full && (pay_head[31:16] >= sta_head[31:16]);
                MODE_HI_LE: verdict = full && (pay_head[31:16] <= sta_head[31:16]);
                MODE_LO_GE: verdict = full && (pay_head[15:0] >= sta_head[15:0]);
                MODE_LO_LE: verdict = full && (pay_head[15:0] <= sta_head[15:0]);
                default:    verdict = 1'b0;
            endcase
            match_q.push_back(cmp_ok && verdict);
            cmp_active = 1'b0;
        end
    endtask

    // drives one byte-pair transaction and waits for its acceptance
    task automatic send_pair(input logic [3:0] evt, input logic [7:0] pay,
                             input logic [7:0] sta, input logic present,
                             input logic empty, input logic last);
        // random sender gaps before the transaction
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sta, pay};
        s_tuser  <= {empty, present, evt};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_pair(evt, pay, sta, present, empty, last);
        items_sent++;
    endtask

    // payload byte with extra weight on all-zero and all-one
    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    // status byte that mostly satisfies the mode, so frames get deep
    function automatic logic [7:0] status_for(input cwc_mode_t mode, input logic [7:0] pay);
        logic [7:0] noise;
        noise = rand_byte();
        case (mode)
            MODE_EXACT:    return pay;
            MODE_ALL_SET:  return pay | noise;
            MODE_NONE_SET: return ~pay & noise;
            default:       return ($urandom_range(3) == 0) ? pay : noise;
        endcase
    endfunction

    // one comparison of len byte pairs; len 0 sends a lone empty-payload transaction
    task automatic send_frame(input logic [3:0] evt, input int len, input bit clean);
        cwc_mode_t  mode;
        logic [3:0] code;
        logic [7:0] pay;
        logic [7:0] sta;
        logic       present;
        logic       empty;
        mode = cwc_mode_t'(evt[2:0]);
        if (len == 0) begin
            send_pair(evt, 8'($urandom), 8'($urandom), 1'($urandom), 1'b1, 1'($urandom));
            return;
        end
        for (int i = 0; i < len; i++) begin
            // event code past the first transaction must be ignored
            code    = (i == 0) ? evt : 4'($urandom);
            pay     = rand_byte();
            sta     = status_for(mode, pay);
            present = 1'b1;
            empty   = 1'b0;
            if (!clean) begin
                if ($urandom_range(9) < 3) sta = 8'($urandom);
                if ($urandom_range(9) < 2) present = 1'b0;
                // a late empty flag counts as an ordinary byte pair
                if (i > 0 && $urandom_range(9) < 3) empty = 1'b1;
            end
            send_pair(code, pay, sta, present, empty, i == len - 1);
        end
    endtask

    // empty payload on the first transaction, tlast low and high
    task automatic test_empty_payload();
        send_pair(4'h8, 8'hFF, 8'h00, 1'b0, 1'b1, 1'b0);  // exact mode, match 1
        send_pair(4'h3, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1);  // reserved mode, match 0
        send_pair(4'hF, 8'hA5, 8'h5A, 1'b1, 1'b1, 1'b1);  // lo le, match 0
    endtask

    // bitwise modes, reserved mode and a missing status byte
    task automatic test_bitwise_modes();
        send_pair(4'h0, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0);
        send_pair(4'h0, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1);  // exact, match 1
        send_pair(4'h1, 8'h0F, 8'h0E, 1'b1, 1'b0, 1'b1);  // bit missing in status
        send_pair(4'h2, 8'hAA, 8'h55, 1'b1, 1'b0, 1'b1);  // disjoint, match 1
        send_pair(4'h3, 8'h5A, 8'h5A, 1'b1, 1'b0, 1'b1);  // reserved, match 0
        send_pair(4'h0, 8'h77, 8'h77, 1'b0, 1'b0, 1'b1);  // no status byte, match 0
    endtask

    // 16-bit compares: full, short and long payloads
    task automatic test_halfword_modes();
        // hi >= with equal halves
        send_pair(4'h4, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0);
        send_pair(4'h4, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0);
        send_pair(4'h4, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0);
        send_pair(4'h4, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b1);
        // hi <= on three bytes only, fails as short
        send_pair(4'h5, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0);
        send_pair(4'h5, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0);
        send_pair(4'h5, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b1);
        // lo >= on five bytes, fifth byte dropped, late empty flag ignored
        send_pair(4'h6, 8'h12, 8'h00, 1'b1, 1'b0, 1'b0);
        send_pair(4'h6, 8'h34, 8'h00, 1'b1, 1'b1, 1'b0);
        send_pair(4'h6, 8'h80, 8'h7F, 1'b1, 1'b0, 1'b0);
        send_pair(4'h6, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0);
        send_pair(4'h6, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b1);
        // lo <= with zero against all ones
        send_pair(4'h7, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
        send_pair(4'h7, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
        send_pair(4'h7, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0);
        send_pair(4'h7, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b1);
    endtask

    // random comparisons under one idling setting
    task automatic test_random_stream(input int idle_pct, input int stall_pct,
                                      input int n_items);
        int start;
        int len;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        start = items_sent;
        while (items_sent - start < n_items) begin
            // mostly short frames, a few empty ones and a few long ones
            if ($urandom_range(11) == 0) len = 0;
            else if ($urandom_range(7) == 0) len = $urandom_range(5, 12);
            else len = $urandom_range(1, 6);
            send_frame(4'($urandom), len, $urandom_range(99) < 85);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_payload();
        test_bitwise_modes();
        test_halfword_modes();

        test_random_stream(0, 0, 210);
        test_random_stream(77, 0, 210);
        test_random_stream(0, 77, 210);
        test_random_stream(10, 10, 220);

        s_tvalid <= 1'b0;
        while (match_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("compound_wait_compare_core verification clean");
        end else begin
            $display("compound_wait_compare_core verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cwc_pkg.sv
rtl/compound_wait_compare_core.sv
tb/sv/compound_wait_compare_core_tb.sv
